/* hw/rtl/fta_pkg.sv */
// ----------------------------------------------------------------------------
// fta_pkg
// Shared types, constants and the cosine table for the flat-top window block.
// ----------------------------------------------------------------------------
package fta_pkg;

  // Frame and table sizing.
  localparam int MAX_FRAME = 8192;
  localparam int IDX_W     = $clog2(MAX_FRAME);
  localparam int FLEN_W    = 14;
  localparam int LEN_W     = (IDX_W + 1 > FLEN_W) ? IDX_W + 1 : FLEN_W;
  localparam int COS_BITS  = 10;
  localparam int ROM_N     = 1 << COS_BITS;
  localparam int ROM_AW    = COS_BITS + 1;
  localparam int COS_W     = 31;

  // Datapath widths.
  localparam int PHASE_W   = 32;
  localparam int STEP_W    = 33;
  localparam int SAMPLE_W  = 24;
  localparam int ACC_W     = 25;
  localparam int MUL_A_W   = ACC_W;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int WGT_W     = 21;
  localparam int NUM_HARM  = 4;

  // Configuration port.
  localparam int APB_AW    = 5;
  localparam int APB_DW    = 64;

  typedef enum logic [1:0] {
    REG_FRAME_LENGTH  = 2'd0,
    REG_PHASE_STEP    = 2'd1,
    REG_WINDOW_OFFSET = 2'd2
  } reg_idx_e;

  localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST  = FLEN_W'(1024);
  localparam logic [STEP_W-1:0]   PHASE_STEP_RST    = STEP_W'(4198404);
  localparam logic [SAMPLE_W-1:0] WINDOW_OFFSET_RST = '0;

  // Q1.20 weights of the four cosine harmonics (magnitudes; signs alternate).
  localparam logic [WGT_W-1:0] WEIGHTS [NUM_HARM] = '{
    WGT_W'(2023752), WGT_W'(1352663), WGT_W'(406847), WGT_W'(33554)
  };
  localparam logic [ACC_W-1:0] ONE_Q20 = ACC_W'(1048576);

  typedef struct packed {
    logic [FLEN_W-1:0]          frame_length;
    logic [STEP_W-1:0]          phase_step;
    logic signed [SAMPLE_W-1:0] window_offset;
  } cfg_t;

  typedef logic [COS_W-1:0] cos_rom_t [0:ROM_N];

  // Quarter-wave cosine in Q1.30 from an even Taylor series, Horner form,
  // each partial sum clamped at zero and the result clamped to one.
  function automatic cos_rom_t build_cos_rom();
    longint   taylor [8];
    longint   u;
    longint   v;
    longint   h;
    cos_rom_t rom;
    taylor = '{64'd1073741824, 64'd1324675879, 64'd272375560, 64'd22401992,
               64'd987048, 64'd27061, 64'd506, 64'd7};
    for (int j = 0; j <= ROM_N; j++) begin
      u = longint'(j) <<< (30 - COS_BITS);
      v = (u * u) >>> 30;
      h = taylor[7];
      for (int k = 6; k >= 0; k--) begin
        h = taylor[k] - ((h * v) >>> 30);
        if (h < 0) h = 0;
      end
      if (h > (longint'(1) <<< 30)) h = longint'(1) <<< 30;
      rom[j] = COS_W'(h);
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

/* hw/rtl/flat_top_window_apply.sv */
// ----------------------------------------------------------------------------
// flat_top_window_apply
// Multiplies a stream of Q1.23 samples by a five-term flat-top window.
//
// A new sample is accepted only from the idle state, so the block does not
// take the next sample before it is through with the last one. One shared
// multiplier forms the four weighted harmonic cosines one after another (fed
// by the registered quarter-wave cosine table, read one harmonic ahead). The
// last harmonic is then added into the window sum, the sample is multiplied
// by the summed window, and the finish state rounds and saturates into the
// output register. The input stalls while an item is in work. A finished beat
// waits in the output register, so the next sample can be taken while it is
// still pending. If that register is still full and stalled when the next
// result is ready, the finish cycle repeats until it is free. Register writes
// take effect on the next sample and do not restart the frame. frame_last
// marks the last sample of each frame, after which index and phase start
// again at zero.
// ----------------------------------------------------------------------------
module flat_top_window_apply (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [fta_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [fta_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                                frame_last_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fta_pkg::APB_AW-1:0]          paddr,
  input  logic [fta_pkg::APB_DW-1:0]          pwdata,
  output logic [fta_pkg::APB_DW-1:0]          prdata,
  output logic                                pready
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_RUN    = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam logic [2:0] STEP_SAMPLE_MUL = 3'(fta_pkg::NUM_HARM + 1);
  localparam logic [2:0] STEP_LAST_ACC   = 3'(fta_pkg::NUM_HARM);
  localparam logic signed [fta_pkg::MUL_P_W-1:0] HALF_TERM =
    fta_pkg::MUL_P_W'(1) <<< 29;
  localparam logic signed [fta_pkg::MUL_P_W-1:0] HALF_OUT =
    fta_pkg::MUL_P_W'(1) <<< 19;
  localparam int YW = fta_pkg::MUL_P_W - 20;
  localparam logic signed [YW-1:0] OUT_MAX = YW'(8388607);
  localparam logic signed [YW-1:0] OUT_MIN = -YW'(8388608);

  fta_pkg::cfg_t cfg;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [fta_pkg::IDX_W-1:0]   sample_index_q, sample_index_d;
  logic [fta_pkg::PHASE_W-1:0] phase_accum_q, phase_accum_d;
  logic [fta_pkg::PHASE_W-1:0] p_q;
  logic signed [fta_pkg::SAMPLE_W-1:0] sample_q;
  logic last_q;
  logic signed [fta_pkg::ACC_W-1:0] acc_q, acc_d;
  logic neg_q;
  logic out_valid_q;
  logic signed [fta_pkg::SAMPLE_W-1:0] sample_out_q;
  logic frame_last_q;

  logic in_accept;
  logic out_load;
  logic [fta_pkg::LEN_W-1:0] len;
  logic frame_last_d;
  logic [fta_pkg::PHASE_W-1:0] ph;
  logic [fta_pkg::COS_BITS-1:0] rom_j;
  logic [fta_pkg::ROM_AW-1:0] rom_addr;
  logic [fta_pkg::COS_W-1:0] rom_rdata;
  logic signed [fta_pkg::MUL_B_W-1:0] cos_val;
  logic signed [fta_pkg::MUL_A_W-1:0] mul_a;
  logic signed [fta_pkg::MUL_B_W-1:0] mul_b;
  logic signed [fta_pkg::MUL_P_W-1:0] prod;
  logic signed [fta_pkg::MUL_P_W-1:0] rnd_term;
  logic signed [fta_pkg::MUL_P_W-1:0] rnd_out;
  logic signed [fta_pkg::ACC_W-1:0] term;
  logic signed [YW-1:0] y_full;
  logic signed [fta_pkg::SAMPLE_W-1:0] y_sat;

  fta_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i);

  // Frame position of the sample being accepted.
  always_comb begin
    len = fta_pkg::LEN_W'(cfg.frame_length);
    if (len < fta_pkg::LEN_W'(2)) len = fta_pkg::LEN_W'(2);
    if (len > fta_pkg::LEN_W'(fta_pkg::MAX_FRAME)) len = fta_pkg::LEN_W'(fta_pkg::MAX_FRAME);
    frame_last_d = fta_pkg::LEN_W'(sample_index_q) >= (len - fta_pkg::LEN_W'(1));
    if (frame_last_d) begin
      sample_index_d = '0;
      phase_accum_d  = '0;
    end else begin
      sample_index_d = sample_index_q + fta_pkg::IDX_W'(1);
      phase_accum_d  = phase_accum_q + cfg.phase_step[fta_pkg::PHASE_W-1:0];
    end
  end

  // Table address runs one harmonic ahead of the multiplier. While idle it
  // points at the first harmonic of the next sample's phase.
  always_comb begin
    if (state_q == ST_IDLE) begin
      ph = phase_accum_q;
    end else begin
      case (step_q)
        3'd0:    ph = p_q << 1;
        3'd1:    ph = p_q + (p_q << 1);
        default: ph = p_q << 2;
      endcase
    end
    rom_j = ph[29 -: fta_pkg::COS_BITS];
    if (ph[30]) begin
      rom_addr = fta_pkg::ROM_AW'(fta_pkg::ROM_N) - {1'b0, rom_j};
    end else begin
      rom_addr = {1'b0, rom_j};
    end
  end

  fta_cos_rom u_rom (
    .clk_i   (clk_i),
    .addr_i  (rom_addr),
    .rdata_o (rom_rdata)
  );

  always_ff @(posedge clk_i) begin
    neg_q <= ph[31] ^ ph[30];
  end

  assign cos_val = neg_q ? -$signed({1'b0, rom_rdata}) : $signed({1'b0, rom_rdata});

  always_comb begin
    if (step_q < 3'(fta_pkg::NUM_HARM)) begin
      mul_a = $signed(fta_pkg::MUL_A_W'(fta_pkg::WEIGHTS[step_q[1:0]]));
      mul_b = cos_val;
    end else begin
      mul_a = acc_q;
      mul_b = fta_pkg::MUL_B_W'(sample_q);
    end
  end

  fta_mul u_mul (
    .clk_i (clk_i),
    .en_i  (state_q == ST_RUN),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Round half up: add half an LSB, then shift arithmetically.
  assign rnd_term = prod + HALF_TERM;
  assign term     = rnd_term[30 +: fta_pkg::ACC_W];
  assign rnd_out  = prod + HALF_OUT;
  assign y_full   = rnd_out[fta_pkg::MUL_P_W-1:20];

  always_comb begin
    if (y_full > OUT_MAX) begin
      y_sat = fta_pkg::SAMPLE_W'(OUT_MAX);
    end else if (y_full < OUT_MIN) begin
      y_sat = fta_pkg::SAMPLE_W'(OUT_MIN);
    end else begin
      y_sat = y_full[fta_pkg::SAMPLE_W-1:0];
    end
  end

  // Accumulate one harmonic per cycle; odd harmonics are subtracted.
  always_comb begin
    acc_d = acc_q;
    if (in_accept) begin
      acc_d = $signed(fta_pkg::ONE_Q20) + fta_pkg::ACC_W'(cfg.window_offset);
    end else if (state_q == ST_RUN && step_q != 3'd0 && step_q <= STEP_LAST_ACC) begin
      acc_d = step_q[0] ? acc_q - term : acc_q + term;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        if (step_q == STEP_SAMPLE_MUL) begin
          state_d = ST_FINISH;
        end else begin
          step_d = step_q + 3'd1;
        end
      end
      ST_FINISH: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      step_q         <= '0;
      sample_index_q <= '0;
      phase_accum_q  <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (in_accept) begin
        sample_index_q <= sample_index_d;
        phase_accum_q  <= phase_accum_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_accept) begin
      p_q      <= phase_accum_q;
      sample_q <= sample_in_i;
      last_q   <= frame_last_d;
    end
    if (out_load) begin
      sample_out_q <= y_sat;
      frame_last_q <= last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign frame_last_o = frame_last_q;

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_RUN) && (step_q == 3'd0))
    else $error("accepted sample did not start the sequencer");

  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && frame_last_d) |=> (sample_index_q == '0) && (phase_accum_q == '0))
    else $error("frame did not restart after its last sample");

  a_finish_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == ST_IDLE))
    else $error("finished result was not loaded into the output register");

  a_run_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (step_q <= STEP_SAMPLE_MUL))
    else $error("sequencer step ran past the sample multiply");

endmodule

/* hw/rtl/fta_cos_rom.sv */
// ----------------------------------------------------------------------------
// fta_cos_rom
// Quarter-wave cosine table with a registered read port.
// ----------------------------------------------------------------------------
module fta_cos_rom (
  input  logic                         clk_i,
  input  logic [fta_pkg::ROM_AW-1:0]   addr_i,
  output logic [fta_pkg::COS_W-1:0]    rdata_o
);

  logic [fta_pkg::COS_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= fta_pkg::COS_ROM[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/fta_mul.sv */
// ----------------------------------------------------------------------------
// fta_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module fta_mul (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [fta_pkg::MUL_A_W-1:0] a_i,
  input  logic signed [fta_pkg::MUL_B_W-1:0] b_i,
  output logic signed [fta_pkg::MUL_P_W-1:0] p_o
);

  logic signed [fta_pkg::MUL_P_W-1:0] p_q;

  // The product holds while disabled so the final sample product can wait.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= fta_pkg::MUL_P_W'(a_i) * fta_pkg::MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/fta_apb_regs.sv */
// ----------------------------------------------------------------------------
// fta_apb_regs
// APB register file holding frame length, phase step and window offset.
// ----------------------------------------------------------------------------
module fta_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fta_pkg::APB_AW-1:0]  paddr,
  input  logic [fta_pkg::APB_DW-1:0]  pwdata,
  output logic [fta_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output fta_pkg::cfg_t               cfg_o
);

  fta_pkg::cfg_t    cfg_q;
  fta_pkg::cfg_t    cfg_d;
  fta_pkg::reg_idx_e idx;
  logic             wr_en;
  logic             addr_hi;

  // Registers sit on 8-byte strides; any address past the last one is unmapped.
  assign idx     = fta_pkg::reg_idx_e'(paddr[4:3]);
  assign addr_hi = (paddr[4:3] == 2'd3);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en && !addr_hi) begin
      unique case (idx)
        fta_pkg::REG_FRAME_LENGTH:  cfg_d.frame_length  = pwdata[fta_pkg::FLEN_W-1:0];
        fta_pkg::REG_PHASE_STEP:    cfg_d.phase_step    = pwdata[fta_pkg::STEP_W-1:0];
        fta_pkg::REG_WINDOW_OFFSET: cfg_d.window_offset = pwdata[fta_pkg::SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_length  <= fta_pkg::FRAME_LENGTH_RST;
      cfg_q.phase_step    <= fta_pkg::PHASE_STEP_RST;
      cfg_q.window_offset <= fta_pkg::WINDOW_OFFSET_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    if (!addr_hi) begin
      unique case (idx)
        fta_pkg::REG_FRAME_LENGTH:
          prdata = fta_pkg::APB_DW'(cfg_q.frame_length);
        fta_pkg::REG_PHASE_STEP:
          prdata = fta_pkg::APB_DW'(cfg_q.phase_step);
        fta_pkg::REG_WINDOW_OFFSET:
          prdata = fta_pkg::APB_DW'(unsigned'(cfg_q.window_offset));
        default: prdata = '0;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
